// ===== design/modular_exponentiation_top_assert.svh =====
// Assertion macros for the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MEXP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MEXP_ASSERT_NOW(lbl, ante, cons)
`define MEXP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/mexp_pkg.sv =====
// Shared types and register indexes for the modular exponentiation core.
package mexp_pkg;

    // Configuration register indexes
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    // Status of the multiply-reduce unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

// ===== design/modular_exponentiation_top.sv =====
// Modular exponentiation core: result = message ** exponent mod modulus.
// An item is taken when i_start is high and o_busy is low; one result follows
// on o_result with a one-cycle o_valid strobe that cannot be held off. Work runs
// left-to-right square-and-multiply through one shared multiply-reduce unit that
// retires one multiplier bit per cycle. An item costs one reduction of the message,
// one squaring per exponent bit and one multiply per set exponent bit. A modulus
// below two gives 0, strobed in the cycle after the item is taken. Configuration
// writes land at once and must only be made while no item is in flight.
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_message,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [WORD_BITS-1:0] i_cfg_data
);

    localparam int W     = WORD_BITS;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT
    } t_state;

    t_state           r_state;
    logic             r_mm_start;
    logic             r_valid;
    logic [W-1:0]     r_result;
    logic [W-1:0]     r_modulus;
    logic [W-1:0]     r_exponent;
    logic [W-1:0]     r_msg;
    logic [W-1:0]     r_base;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_e;
    logic [CNT_W-1:0] r_cnt;

    t_mm_stat         mm_stat;
    logic [W-1:0]     mm_p;
    logic [W-1:0]     mm_a;
    logic [W-1:0]     mm_b;
    logic             accept;

    assign accept = i_start && (r_state == ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= W'(2);
            r_exponent <= W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Operand select for the shared unit
    always_comb begin
        unique case (r_state)
            ST_REDUCE: begin
                mm_a = W'(1);
                mm_b = r_msg;
            end
            ST_SQUARE: begin
                mm_a = r_acc;
                mm_b = r_acc;
            end
            ST_MULT: begin
                mm_a = r_acc;
                mm_b = r_base;
            end
            default: begin
                mm_a = r_acc;
                mm_b = r_acc;
            end
        endcase
    end

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_modulus),
        .o_stat  (mm_stat),
        .o_p     (mm_p)
    );

    // Sequencer: reduce base, then square and multiply over exponent bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mm_start <= 1'b0;
            r_valid    <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_mm_start <= 1'b0;
            r_valid    <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (r_modulus < W'(2)) begin
                            r_result <= '0;
                            r_valid  <= 1'b1;
                        end else begin
                            r_msg      <= i_message;
                            r_e        <= r_exponent;
                            r_cnt      <= CNT_W'(W - 1);
                            r_mm_start <= 1'b1;
                            r_state    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (mm_stat.done) begin
                        r_base     <= mm_p;
                        r_acc      <= W'(1);
                        r_mm_start <= 1'b1;
                        r_state    <= ST_SQUARE;
                    end
                end
                ST_SQUARE, ST_MULT: begin
                    if (mm_stat.done) begin
                        r_acc <= mm_p;
                        if (r_state == ST_SQUARE && r_e[W-1]) begin
                            r_mm_start <= 1'b1;
                            r_state    <= ST_MULT;
                        end else if (r_cnt == '0) begin
                            r_result <= mm_p;
                            r_valid  <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_cnt      <= r_cnt - 1'b1;
                            r_e        <= {r_e[W-2:0], 1'b0};
                            r_mm_start <= 1'b1;
                            r_state    <= ST_SQUARE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Checks
    `include "modular_exponentiation_top_assert.svh"

    `MEXP_ASSERT_NEXT(a_accept_then_work, accept, o_busy || o_valid)
    `MEXP_ASSERT_NOW(a_strobe_when_idle, o_valid, !o_busy)
    `MEXP_ASSERT_NOW(a_unit_done_in_job, mm_stat.done, r_state != ST_IDLE)
    `MEXP_ASSERT_NOW(a_unit_busy_in_job, mm_stat.busy, r_state != ST_IDLE)

endmodule

// ===== design/mexp_mulmod.sv =====
// Iterative modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output t_mm_stat     o_stat,
    output logic [W-1:0] o_p
);

    localparam int CNT_W = $clog2(W);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_m;

    logic [W+1:0]     t_sum;
    logic [W+1:0]     t_m1;
    logic [W+1:0]     t_m2;
    logic [W+1:0]     t_red;

    // 2*acc + bit*a stays below 3m: subtract m or 2m as needed
    always_comb begin
        t_sum = {1'b0, r_acc, 1'b0} + {2'b00, (r_b[W-1] ? r_a : {W{1'b0}})};
        t_m1  = {2'b00, r_m};
        t_m2  = {1'b0, r_m, 1'b0};
        if (t_sum >= t_m2) begin
            t_red = t_sum - t_m2;
        end else if (t_sum >= t_m1) begin
            t_red = t_sum - t_m1;
        end else begin
            t_red = t_sum;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(W - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_run) begin
            r_acc <= t_red[W-1:0];
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;
    assign o_p         = r_acc;

endmodule
